[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the bit timing solver modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define CBTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define CBTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define CBTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CBTS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[sv/cbts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbts_pkg
// Widths, constants and control types of the CAN bit timing solver.
// ----------------------------------------------------------------------------
package cbts_pkg;

   // field widths
   localparam int CLK_W   = 29;
   localparam int BAUD_W  = 24;
   localparam int PRESC_W = 16;
   localparam int SEG_W   = 6;
   localparam int SJW_W   = 7;

   // clock register after reset
   localparam logic [CLK_W-1:0] CLK_RESET = 29'd200000000;

   // default search range
   localparam int DEF_MAX_SEGMENTS = 48;
   localparam int DEF_MIN_SEGMENTS = 4;

   // error below 1/TOL_FINE ends the search
   localparam int TOL_FINE = 100000;

   // sync jump width and prescaler limits
   localparam int SJW_DIVIDEND = 200;
   localparam int SJW_MAX      = 127;
   localparam int PRESC_MAX    = 65535;

   // x / 10 as (x * RECIP_TEN) >> RECIP_SHIFT, exact for x below 16384
   localparam int RECIP_TEN   = 6554;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;

   // divider control and status
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

[sv/cbts_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbts_ifs
// Valid/ready channels of the solver: request, response and clock register.
// ----------------------------------------------------------------------------
interface cbts_req_if;
   import cbts_pkg::*;
   logic              valid;
   logic              ready;
   logic [BAUD_W-1:0] req_rate;
   modport source (output valid, output req_rate, input ready);
   modport sink   (input valid, input req_rate, output ready);
endinterface

interface cbts_rsp_if;
   import cbts_pkg::*;
   logic               valid;
   logic               ready;
   logic               ok;
   logic [PRESC_W-1:0] prescaler;
   logic [SEG_W-1:0]   seg1;
   logic [SEG_W-1:0]   seg2;
   logic [SJW_W-1:0]   sjw;
   modport source (output valid, output ok, output prescaler, output seg1,
                   output seg2, output sjw, input ready);
   modport sink   (input valid, input ok, input prescaler, input seg1,
                   input seg2, input sjw, output ready);
endinterface

interface cbts_csr_if;
   import cbts_pkg::*;
   logic             valid;
   logic             ready;
   logic [CLK_W-1:0] clock_hz;
   modport source (output valid, output clock_hz, input ready);
   modport sink   (input valid, input clock_hz, output ready);
endinterface

[sv/can_bit_timing_solver.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// can_bit_timing_solver
// Searches segment counts for the CAN bit timing closest to a requested rate.
// ----------------------------------------------------------------------------
//  channel    dir  handshake    payload
//  csr_chan   in   valid/ready  clock_hz (29 b), always ready
//  req_chan   in   valid/ready  req_rate (24 b), ready only when idle
//  rsp_chan   out  valid/ready  ok, prescaler, seg1, seg2, sjw
//
//  Each candidate passes through the serial divider for clock / (baud*(i+1))
//  and through one multiplier; the first candidate skips the comparison.
//  A full search covers 45 candidates; the prescaler checks, the sjw division
//  and the segments follow before a result leaves.
//  Reset is synchronous and restores the clock register to 200 MHz.
//  A held response does not stop the next request; its result waits in S_OUT.
// ----------------------------------------------------------------------------
module can_bit_timing_solver #(
   parameter int MAX_SEGMENTS = cbts_pkg::DEF_MAX_SEGMENTS,
   parameter int MIN_SEGMENTS = cbts_pkg::DEF_MIN_SEGMENTS
) (
   input logic         clock,
   input logic         reset,
   cbts_csr_if.sink    csr_chan,
   cbts_req_if.sink    req_chan,
   cbts_rsp_if.source  rsp_chan
);
   import cbts_pkg::*;

   localparam int  TOP_SEG      = (MAX_SEGMENTS > MIN_SEGMENTS) ? MAX_SEGMENTS : MIN_SEGMENTS;
   localparam int  CNT_W        = $clog2(TOP_SEG + 2);
   localparam int  D_W          = BAUD_W + CNT_W;
   localparam int  R_W          = (D_W < CLK_W) ? D_W : CLK_W;
   localparam int  P_W          = D_W + R_W;
   localparam int  X_W          = CNT_W + 4;
   localparam int  XP_W         = X_W + RECIP_W;
   localparam int  T_W          = XP_W - RECIP_SHIFT;
   localparam int  SG_W         = (T_W > SEG_W) ? T_W : SEG_W;
   localparam int  CW           = D_W + 5;
   localparam bit  EMPTY_SEARCH = (MIN_SEGMENTS > MAX_SEGMENTS);
   localparam logic [CNT_W-1:0] I_MAX = CNT_W'(MAX_SEGMENTS);
   localparam logic [CNT_W-1:0] I_MIN = CNT_W'(MIN_SEGMENTS);

   typedef enum logic [14:0] {
      S_IDLE   = 15'h0001,
      S_MULD   = 15'h0002,
      S_DSTART = 15'h0004,
      S_DIV    = 15'h0008,
      S_FOLD   = 15'h0010,
      S_MULE   = 15'h0020,
      S_CHKE   = 15'h0040,
      S_MULA   = 15'h0080,
      S_MULB   = 15'h0100,
      S_CMP    = 15'h0200,
      S_PRE    = 15'h0400,
      S_SSTART = 15'h0800,
      S_SDIV   = 15'h1000,
      S_SEG    = 15'h2000,
      S_OUT    = 15'h4000
   } state_type;

   state_type          state_ff, state_in;
   logic [CLK_W-1:0]   clk_hz_ff, clk_hz_in;
   logic               have_ff, have_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [BAUD_W-1:0]  baud_ff, baud_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [R_W-1:0]     r_ff, r_in;
   logic [P_W-1:0]     cmp_ff, cmp_in;
   logic [CNT_W-1:0]   best_i_ff, best_i_in;
   logic [R_W-1:0]     best_r_ff, best_r_in;
   logic [D_W-1:0]     best_d_ff, best_d_in;
   logic [R_W-1:0]     best_rem_ff, best_rem_in;
   logic [CLK_W-1:0]   best_q_ff, best_q_in;
   logic [PRESC_W-1:0] presc_ff, presc_in;
   logic               fail_ff, fail_in;
   logic [SEG_W-1:0]   seg1_ff, seg1_in;
   logic [SEG_W-1:0]   seg2_ff, seg2_in;
   logic [SJW_W-1:0]   sjw_ff, sjw_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [PRESC_W-1:0] rsp_presc_ff, rsp_presc_in;
   logic [SEG_W-1:0]   rsp_seg1_ff, rsp_seg1_in;
   logic [SEG_W-1:0]   rsp_seg2_ff, rsp_seg2_in;
   logic [SJW_W-1:0]   rsp_sjw_ff, rsp_sjw_in;

   // shared units
   logic [D_W-1:0]     mul_a;
   logic [R_W-1:0]     mul_b;
   logic [P_W-1:0]     mul_p;
   div_ctl_type        div_ctl;
   div_sts_type        div_sts;
   logic [CLK_W-1:0]   div_dividend;
   logic [D_W-1:0]     div_divisor;
   logic [CLK_W-1:0]   div_quot;
   logic [D_W-1:0]     div_rem;

   // datapath terms
   logic [CNT_W-1:0]   i_plus;
   logic [R_W-1:0]     rem_w;
   logic               fold_up;
   logic [R_W-1:0]     fold_r;
   logic               fine_hit;
   logic               better;
   logic               at_min;
   logic               round_up;
   logic [CLK_W:0]     presc_full;
   logic               coarse_fail;
   logic               presc_bad;
   logic [X_W-1:0]     seg_ip;
   logic [X_W-1:0]     seg_x;
   logic [XP_W-1:0]    seg_xp;
   logic [SG_W-1:0]    s1_raw;
   logic [SG_W-1:0]    s1;
   logic [SG_W-1:0]    s2;
   logic [7:0]         sjw_q;
   logic [SJW_W-1:0]   sjw_val;
   logic               take;
   logic               rsp_free;

   // response checks
   logic               rsp_zero;
   logic               rsp_nonzero;
   logic               req_take;

   cbts_mul #(.A_W(D_W), .B_W(R_W)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   cbts_div #(.DIVIDEND_W(CLK_W), .DIVISOR_W(D_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .sts       (div_sts),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // select multiplier operands by step
   assign i_plus = i_ff + CNT_W'(1);
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MULD: begin
            mul_a = D_W'(baud_ff);
            mul_b = R_W'(i_plus);
         end
         S_MULE: begin
            mul_a = D_W'(TOL_FINE);
            mul_b = r_ff;
         end
         S_MULA: begin
            mul_a = best_d_ff;
            mul_b = r_ff;
         end
         S_MULB: begin
            mul_a = d_ff;
            mul_b = best_r_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // drive the divider: clock by d for the search, 200 by prescaler for sjw
   assign div_ctl.start = (state_ff == S_DSTART) || (state_ff == S_SSTART);
   assign div_dividend  = (state_ff == S_DSTART) ? clk_hz_ff : CLK_W'(SJW_DIVIDEND);
   assign div_divisor   = (state_ff == S_DSTART) ? mul_p[D_W-1:0] : D_W'(presc_ff);

   // fold the remainder to its distance from the nearest multiple
   assign rem_w   = div_rem[R_W-1:0];
   assign fold_up = (D_W+1)'({rem_w, 1'b0}) > (D_W+1)'(d_ff);
   assign fold_r  = fold_up ? R_W'(d_ff - D_W'(rem_w)) : rem_w;

   // candidate tests
   assign fine_hit = mul_p < P_W'(d_ff);
   assign better   = cmp_ff < mul_p;
   assign at_min   = (i_ff == I_MIN);

   // prescaler rounding and failure checks
   assign round_up    = (D_W+1)'({best_rem_ff, 1'b0}) >= (D_W+1)'(best_d_ff);
   assign presc_full  = (CLK_W+1)'(best_q_ff) + (CLK_W+1)'(round_up);
   assign coarse_fail = (CW'({best_r_ff, 3'b000}) + CW'({best_r_ff, 1'b0}))
                        > CW'(best_d_ff);
   assign presc_bad   = (presc_full == '0) || (presc_full > (CLK_W+1)'(PRESC_MAX));

   // seg1 = round(0.7 * (i + 1)) - 1, kept inside 1 .. i-1
   assign seg_ip = X_W'(best_i_ff) + X_W'(1);
   assign seg_x  = (seg_ip << 3) - seg_ip + X_W'(5);
   assign seg_xp = XP_W'(seg_x) * XP_W'(RECIP_TEN);
   assign s1_raw = SG_W'(seg_xp[XP_W-1:RECIP_SHIFT]) - SG_W'(1);
   always_comb begin
      if (s1_raw == '0) begin
         s1 = SG_W'(1);
      end else if (s1_raw == SG_W'(best_i_ff)) begin
         s1 = s1_raw - SG_W'(1);
      end else begin
         s1 = s1_raw;
      end
   end
   assign s2 = SG_W'(best_i_ff) - s1;

   // clamp the sync jump width
   assign sjw_q = div_quot[7:0];
   always_comb begin
      if (sjw_q == '0) begin
         sjw_val = SJW_W'(1);
      end else if (sjw_q > 8'(SJW_MAX)) begin
         sjw_val = SJW_W'(SJW_MAX);
      end else begin
         sjw_val = sjw_q[SJW_W-1:0];
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clk_hz_in    = clk_hz_ff;
      have_in      = have_ff;
      baud_in      = baud_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      cmp_in       = cmp_ff;
      best_i_in    = best_i_ff;
      best_r_in    = best_r_ff;
      best_d_in    = best_d_ff;
      best_rem_in  = best_rem_ff;
      best_q_in    = best_q_ff;
      presc_in     = presc_ff;
      fail_in      = fail_ff;
      seg1_in      = seg1_ff;
      seg2_in      = seg2_ff;
      sjw_in       = sjw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_presc_in = rsp_presc_ff;
      rsp_seg1_in  = rsp_seg1_ff;
      rsp_seg2_in  = rsp_seg2_ff;
      rsp_sjw_in   = rsp_sjw_ff;
      take         = 1'b0;

      // take a clock register write
      if (csr_chan.valid) begin
         clk_hz_in = csr_chan.clock_hz;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               baud_in = req_chan.req_rate;
               i_in    = I_MAX;
               have_in = 1'b0;
               if ((req_chan.req_rate == '0) || EMPTY_SEARCH) begin
                  state_in = S_PRE;
               end else begin
                  state_in = S_MULD;
               end
            end
         end
         S_MULD: begin
            state_in = S_DSTART;
         end
         S_DSTART: begin
            d_in     = mul_p[D_W-1:0];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_sts.done) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            r_in     = fold_r;
            state_in = S_MULE;
         end
         S_MULE: begin
            state_in = S_CHKE;
         end
         S_CHKE: begin
            if (fine_hit) begin
               take     = 1'b1;
               state_in = S_PRE;
            end else if (!have_ff) begin
               take = 1'b1;
               if (at_min) begin
                  state_in = S_PRE;
               end else begin
                  i_in     = i_ff - CNT_W'(1);
                  state_in = S_MULD;
               end
            end else begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            state_in = S_MULB;
         end
         S_MULB: begin
            cmp_in   = mul_p;
            state_in = S_CMP;
         end
         S_CMP: begin
            take = better;
            if (at_min) begin
               state_in = S_PRE;
            end else begin
               i_in     = i_ff - CNT_W'(1);
               state_in = S_MULD;
            end
         end
         S_PRE: begin
            presc_in = presc_full[PRESC_W-1:0];
            fail_in  = !have_ff || coarse_fail || presc_bad;
            if (!have_ff || coarse_fail || presc_bad) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SSTART;
            end
         end
         S_SSTART: begin
            state_in = S_SDIV;
         end
         S_SDIV: begin
            if (div_sts.done) begin
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            seg1_in  = s1[SEG_W-1:0];
            seg2_in  = s2[SEG_W-1:0];
            sjw_in   = sjw_val;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = !fail_ff;
               rsp_presc_in = fail_ff ? '0 : presc_ff;
               rsp_seg1_in  = fail_ff ? '0 : seg1_ff;
               rsp_seg2_in  = fail_ff ? '0 : seg2_ff;
               rsp_sjw_in   = fail_ff ? '0 : sjw_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // record the candidate as the best so far
      if (take) begin
         have_in     = 1'b1;
         best_i_in   = i_ff;
         best_r_in   = r_ff;
         best_d_in   = d_ff;
         best_rem_in = rem_w;
         best_q_in   = div_quot;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clk_hz_ff    <= CLK_RESET;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_hz_ff    <= clk_hz_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      baud_ff      <= baud_in;
      i_ff         <= i_in;
      d_ff         <= d_in;
      r_ff         <= r_in;
      cmp_ff       <= cmp_in;
      best_i_ff    <= best_i_in;
      best_r_ff    <= best_r_in;
      best_d_ff    <= best_d_in;
      best_rem_ff  <= best_rem_in;
      best_q_ff    <= best_q_in;
      presc_ff     <= presc_in;
      fail_ff      <= fail_in;
      seg1_ff      <= seg1_in;
      seg2_ff      <= seg2_in;
      sjw_ff       <= sjw_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_presc_ff <= rsp_presc_in;
      rsp_seg1_ff  <= rsp_seg1_in;
      rsp_seg2_ff  <= rsp_seg2_in;
      rsp_sjw_ff   <= rsp_sjw_in;
   end

   // ports
   assign csr_chan.ready     = 1'b1;
   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.ok        = rsp_ok_ff;
   assign rsp_chan.prescaler = rsp_presc_ff;
   assign rsp_chan.seg1      = rsp_seg1_ff;
   assign rsp_chan.seg2      = rsp_seg2_ff;
   assign rsp_chan.sjw       = rsp_sjw_ff;

   // summarise the held response for the checks below
   assign rsp_zero    = (rsp_presc_ff == '0) && (rsp_seg1_ff == '0) &&
                        (rsp_seg2_ff == '0) && (rsp_sjw_ff == '0);
   assign rsp_nonzero = (rsp_presc_ff != '0) && (rsp_sjw_ff != '0);
   assign req_take    = req_chan.valid && (state_ff == S_IDLE);

   `CBTS_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_zero)
   `CBTS_ASSERT_IMPLY(a_ok_nonzero, clock, reset, rsp_valid_ff && rsp_ok_ff, rsp_nonzero)
   `CBTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, state_ff != S_IDLE)
   `CBTS_ASSERT_IMPLY(a_div_free_at_start, clock, reset, div_ctl.start, !div_sts.busy)
   `CBTS_ASSERT_NEXT(a_out_loads, clock, reset, (state_ff == S_OUT) && !rsp_valid_ff, rsp_valid_ff)

endmodule

[sv/cbts_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbts_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cbts_mul #(
   parameter int A_W = cbts_pkg::CLK_W,
   parameter int B_W = cbts_pkg::CLK_W
) (
   input  logic             clock,
   input  logic [A_W-1:0]   op_a,
   input  logic [B_W-1:0]   op_b,
   output logic [A_W+B_W-1:0] product
);
   import cbts_pkg::*;

   logic [A_W+B_W-1:0] prod_ff;
   logic [A_W+B_W-1:0] prod_in;

   // form the full-width product
   assign prod_in = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);

   // hold it for the next cycle
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

[sv/cbts_div.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cbts_div
// Restoring divider, one quotient bit a cycle, remainder and quotient held.
// ----------------------------------------------------------------------------
module cbts_div #(
   parameter int DIVIDEND_W = cbts_pkg::CLK_W,
   parameter int DIVISOR_W  = cbts_pkg::CLK_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cbts_pkg::div_ctl_type    ctl,
   input  logic [DIVIDEND_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0]     divisor,
   output cbts_pkg::div_sts_type    sts,
   output logic [DIVIDEND_W-1:0]    quotient,
   output logic [DIVISOR_W-1:0]     remainder
);
   import cbts_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W-1:0]  part_ff, part_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // bring down the next dividend bit and trial-subtract
   assign shifted = {part_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   // load on start, otherwise step until the count runs out
   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      part_in = part_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         cnt_in  = CNT_W'(DIVIDEND_W);
         part_in = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (cnt_ff != '0) begin
         part_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      part_ff <= part_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign sts.busy  = (cnt_ff != '0);
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = part_ff;

   `CBTS_ASSERT_IMPLY(a_rem_below_divisor, clock, reset, done_ff, part_ff < dsr_ff)
   `CBTS_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)
   `CBTS_ASSERT_NEXT(a_start_busy, clock, reset, ctl.start, cnt_ff != '0)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN bit timing solver. Bit rate requests are
// driven through the request channel under several clock settings and
// handshake pressure patterns. Each accepted rate is solved by a local search
// model, and every response is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import cbts_pkg::*;

   // handshake pressure patterns
   typedef enum int {
      FLOW_FREE,
      FLOW_SEND_GAPS,
      FLOW_RECV_STALLS,
      FLOW_BOTH_LIGHT
   } flow_mode_type;

   // one solved bit timing, as the response channel carries it
   typedef struct packed {
      logic               ok;
      logic [PRESC_W-1:0] prescaler;
      logic [SEG_W-1:0]   seg1;
      logic [SEG_W-1:0]   seg2;
      logic [SJW_W-1:0]   sjw;
   } bit_timing_type;

   localparam int HANG_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 2000;
   localparam logic [BAUD_W-1:0] BAUD_TOP = {BAUD_W{1'b1}};
   localparam logic [CLK_W-1:0]  CLK_TOP  = {CLK_W{1'b1}};

   logic clock;
   logic reset;

   cbts_csr_if csr_if ();
   cbts_req_if req_if ();
   cbts_rsp_if rsp_if ();

   can_bit_timing_solver dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_if),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // bench state
   logic [BAUD_W-1:0] baud_backlog[$];
   bit_timing_type    timing_due[$];
   logic [CLK_W-1:0]  clock_model;
   flow_mode_type     flow_mode;
   bit                rate_taken;
   int                rates_queued;
   int                timings_checked;
   int                clock_writes;
   int                mismatches;
   int                quiet_cycles;
   int unsigned       can_rates[10] = '{10000, 20000, 50000, 83333, 100000,
                                        125000, 250000, 500000, 800000, 1000000};

   // Solve one rate: search segment totals from the top down, stop on a
   // near-exact fit, else keep the first strictly better error.
   function automatic bit_timing_type solve_timing(input logic [BAUD_W-1:0] baud,
                                                   input logic [CLK_W-1:0] clk_hz);
      bit_timing_type res;
      logic [63:0] d, rem, r, best_d, best_r, best_rem, best_i, presc, s1, jump;
      bit          found;
      int          i;
      res      = '0;
      found    = 1'b0;
      best_i   = 0;
      best_d   = 1;
      best_r   = 0;
      best_rem = 0;
      if (baud == 0) return res;
      for (i = DEF_MAX_SEGMENTS; i >= DEF_MIN_SEGMENTS; i--) begin
         d   = 64'(baud) * 64'(i + 1);
         rem = 64'(clk_hz) % d;
         r   = (2 * rem > d) ? d - rem : rem;
         if (r * 64'(TOL_FINE) < d || !found || r * best_d < best_r * d) begin
            found    = 1'b1;
            best_i   = 64'(i);
            best_r   = r;
            best_d   = d;
            best_rem = rem;
            if (r * 64'(TOL_FINE) < d) break;
         end
      end
      if (!found || best_r * 10 > best_d) return res;
      presc = 64'(clk_hz) / best_d;
      if (2 * best_rem >= best_d) presc = presc + 1;
      if (presc == 0 || presc > 64'(PRESC_MAX)) return res;
      // sample point at 70 percent, kept off both ends
      s1 = (7 * (best_i + 1) + 5) / 10 - 1;
      if (s1 == 0) s1 = 1;
      else if (s1 == best_i) s1 = s1 - 1;
      jump = 64'(SJW_DIVIDEND) / presc;
      if (jump < 1) jump = 1;
      else if (jump > 64'(SJW_MAX)) jump = 64'(SJW_MAX);
      res.ok        = 1'b1;
      res.prescaler = presc[PRESC_W-1:0];
      res.seg1      = s1[SEG_W-1:0];
      res.seg2      = 6'(best_i - s1);
      res.sjw       = jump[SJW_W-1:0];
      return res;
   endfunction

   // Decide whether a side holds off this cycle.
   function automatic bit hold_now(input bit for_sender);
      int unsigned roll;
      roll = $urandom_range(99);
      case (flow_mode)
         FLOW_SEND_GAPS:   return for_sender && roll < 77;
         FLOW_RECV_STALLS: return !for_sender && roll < 77;
         FLOW_BOTH_LIGHT:  return roll < 9;
         default:          return 1'b0;
      endcase
   endfunction

   // Draw one rate: most often rates that a prescaler and segment pair hits
   // exactly or nearly, then common bus rates, raw noise and the edges.
   function automatic logic [BAUD_W-1:0] pick_baud(input logic [CLK_W-1:0] clk_hz);
      int unsigned kind, segs, presc;
      logic [63:0] v;
      kind = $urandom_range(99);
      v    = 0;
      if (kind < 40 && clk_hz != 0) begin
         segs  = $urandom_range(DEF_MAX_SEGMENTS + 1, DEF_MIN_SEGMENTS + 1);
         presc = (kind < 25) ? $urandom_range(40, 1) : $urandom_range(70000, 1);
         v     = 64'(clk_hz) / (64'(segs) * 64'(presc));
         if ($urandom_range(3) == 0 && v > 1) v = v + 64'd1 - 64'(2 * $urandom_range(1));
      end
      if (v != 0 && v <= 64'(BAUD_TOP)) return v[BAUD_W-1:0];
      if (kind < 65) begin
         v = 64'(can_rates[$urandom_range(9)]);
         if ($urandom_range(2) == 0) v = v + 64'($urandom_range(200)) - 64'd100;
         return v[BAUD_W-1:0];
      end
      if (kind < 80) return BAUD_W'($urandom()) & BAUD_TOP;
      if (kind < 90) return BAUD_W'($urandom_range(300, 1));
      return BAUD_TOP - BAUD_W'($urandom_range(1023));
   endfunction

   // Queue one rate for the driver.
   task automatic queue_rate(input logic [BAUD_W-1:0] baud);
      baud_backlog.push_back(baud);
      rates_queued++;
   endtask

   // Wait until every queued rate has come back as a checked timing.
   task automatic wait_drained();
      while (timings_checked != rates_queued) @(negedge clock);
   endtask

   // Write the clock register while the block is idle.
   task automatic write_clock(input logic [CLK_W-1:0] value);
      int target;
      target = clock_writes + 1;
      @(negedge clock);
      csr_if.valid    <= 1'b1;
      csr_if.clock_hz <= value;
      do @(negedge clock); while (clock_writes != target);
      csr_if.valid <= 1'b0;
   endtask

   // Clock, reset and known input levels from time zero
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_rate = '0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.clock_hz = '0;
      forever #1 clock = ~clock;
   end

   // Request driver: hold an item until taken, then load the next one
   always @(negedge clock) begin
      logic              next_valid;
      logic [BAUD_W-1:0] next_baud;
      next_valid = req_if.valid;
      next_baud  = req_if.req_rate;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_if.valid || rate_taken) begin
         next_valid = 1'b0;
         if (baud_backlog.size() != 0 && !hold_now(1'b1)) begin
            next_valid = 1'b1;
            next_baud  = baud_backlog.pop_front();
         end
      end
      req_if.valid    <= next_valid;
      req_if.req_rate <= next_baud;
   end

   // Response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !hold_now(1'b0);
      end
   end

   // Monitor: track the register, solve accepted rates, check responses,
   // and end the run if nothing moves for too long
   always @(posedge clock) begin
      bit_timing_type got, want;
      bit             moved;
      if (reset) begin
         clock_model  = CLK_RESET;
         rate_taken   = 1'b0;
         quiet_cycles = 0;
      end else begin
         moved      = 1'b0;
         rate_taken = req_if.valid && req_if.ready;
         if (csr_if.valid && csr_if.ready) begin
            clock_model = csr_if.clock_hz;
            clock_writes++;
            moved = 1'b1;
         end
         if (rate_taken) begin
            timing_due.push_back(solve_timing(req_if.req_rate, clock_model));
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            got   = '{rsp_if.ok, rsp_if.prescaler, rsp_if.seg1, rsp_if.seg2,
                      rsp_if.sjw};
            if (timing_due.size() == 0) begin
               $display("%0t: unexpected timing ok=%0b presc=%0d seg1=%0d seg2=%0d sjw=%0d",
                        $time, got.ok, got.prescaler, got.seg1, got.seg2, got.sjw);
               mismatches++;
            end else begin
               want = timing_due.pop_front();
               if (got.ok !== want.ok || got.prescaler !== want.prescaler ||
                   got.seg1 !== want.seg1 || got.seg2 !== want.seg2 ||
                   got.sjw !== want.sjw) begin
                  $display({"%0t: timing mismatch expected ",
                            "ok=%0b presc=%0d seg1=%0d seg2=%0d sjw=%0d"},
                           $time, want.ok, want.prescaler, want.seg1, want.seg2,
                           want.sjw);
                  $display({"%0t:                 actual   ",
                            "ok=%0b presc=%0d seg1=%0d seg2=%0d sjw=%0d"},
                           $time, got.ok, got.prescaler, got.seg1, got.seg2,
                           got.sjw);
                  mismatches++;
               end
               timings_checked++;
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // Stimulus: directed rates first, then random phases across clock settings
   initial begin
      logic [CLK_W-1:0] phase_clock[9];
      flow_mode_type    phase_flow[9];
      int               phase_items[9];
      int               p, n;
      phase_clock = '{CLK_RESET, CLK_TOP, 29'd1, 29'd0, 29'd80000000, 29'd40000000,
                      29'd16000000, 29'd0, CLK_RESET};
      phase_flow  = '{FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH_LIGHT,
                      FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH_LIGHT,
                      FLOW_BOTH_LIGHT};
      phase_items = '{40, 50, 20, 10, 60, 60, 60, 50, 30};
      rates_queued    = 0;
      timings_checked = 0;
      clock_writes    = 0;
      mismatches      = 0;
      flow_mode       = FLOW_FREE;
      // random clock for the second to last phase, kept high enough to solve
      phase_clock[7] = CLK_W'($urandom_range(CLK_TOP, 8000000));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field edges, bit patterns, overflow edge, exact fits
      queue_rate(24'd0);
      queue_rate(24'd1);
      queue_rate(BAUD_TOP);
      queue_rate(24'hAAAAAA);
      queue_rate(24'h555555);
      queue_rate(24'd7);
      queue_rate(24'd61);
      queue_rate(24'd62);
      queue_rate(24'd63);
      queue_rate(24'd10000);
      queue_rate(24'd125000);
      queue_rate(24'd250000);
      queue_rate(24'd500000);
      queue_rate(24'd800000);
      queue_rate(24'd1000000);
      queue_rate(24'd3333333);
      queue_rate(24'd4000000);
      queue_rate(24'd5000000);
      queue_rate(24'd8000000);
      queue_rate(24'd16000000);

      for (p = 0; p < 9; p++) begin
         wait_drained();
         // the first phase runs on the clock left by reset
         if (p != 0) write_clock(phase_clock[p]);
         flow_mode = phase_flow[p];
         for (n = 0; n < phase_items[p]; n++) queue_rate(pick_baud(phase_clock[p]));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && timing_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
